### sv/vtbr_pkg.sv
// ----------------------------------------------------------------------------
// vtbr_pkg
// Shared widths, register indexes and controller/datapath interface types
// for the vertex transform and bounding radius block.
// ----------------------------------------------------------------------------
package vtbr_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int VTX_W    = 32;
    localparam int TRIG_W   = 18;
    localparam int SCALED_W = 45;
    localparam int RSQ_W    = 63;
    localparam int ROOT_W   = 32;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_COS_ROT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN_ROT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_X   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_Y   = 3'd5;

    // Largest magnitude whose square still fits in 63 bits.
    localparam logic [SCALED_W-1:0] SQ_LIMIT = 45'd3037000499;
    localparam logic [RSQ_W-1:0]    RSQ_MAX  = {RSQ_W{1'b1}};

    typedef enum logic [1:0] {
        ROT_XC = 2'd0,
        ROT_YS = 2'd1,
        ROT_XS = 2'd2,
        ROT_YC = 2'd3
    } t_rot_sel;

    typedef struct packed {
        logic     load_in;
        logic     mul_vx;
        logic     mul_vy;
        logic     ld_sx;
        logic     ld_sy;
        logic     sq_x;
        logic     sq_y;
        logic     sqx_ld;
        logic     len_ld;
        logic     max_upd;
        logic     rot_en;
        t_rot_sel rot_sel;
        logic     accx_ld;
        logic     accx_sub;
        logic     accy_ld;
        logic     accy_add;
        logic     wx_ld;
        logic     wy_ld;
        logic     sqrt_start;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic sqrt_done;
        logic out_free;
    } t_status;

endpackage

### sv/vtbr_sqrt.sv
// ----------------------------------------------------------------------------
// vtbr_sqrt
// Iterative integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module vtbr_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [vtbr_pkg::RSQ_W-1:0]   i_value,
    output logic                         o_done,
    output logic [vtbr_pkg::ROOT_W-1:0]  o_root
);
    import vtbr_pkg::*;

    localparam int X_W   = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(ROOT_W);

    logic [X_W-1:0]    r_x;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  trial;
    logic              fits;

    assign rem_shift = {r_rem[REM_W-3:0], r_x[X_W-1 -: 2]};
    assign trial     = {r_root, 2'b01};
    assign fits      = rem_shift >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= {1'b0, i_value};
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x <= {r_x[X_W-3:0], 2'b00};
            if (fits) begin
                r_rem  <= rem_shift - trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_shift;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

### sv/vtbr_dp.sv
// ----------------------------------------------------------------------------
// vtbr_dp
// Datapath: configuration registers, scale and rotation multipliers,
// accumulators, running maximum, square root unit and output register.
// ----------------------------------------------------------------------------
module vtbr_dp #(
    parameter int FRAC_BITS = vtbr_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [vtbr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [vtbr_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic [63:0]                     i_s_axis_tdata,
    input  logic                            i_s_axis_tlast,
    input  vtbr_pkg::t_cmd                  i_cmd,
    output vtbr_pkg::t_status               o_status,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [159:0]                    o_m_axis_tdata,
    output logic [0:0]                      o_m_axis_tuser
);
    import vtbr_pkg::*;

    localparam logic [TRIG_W-1:0] COS_RST   = TRIG_W'(64'd1 << FRAC_BITS);
    localparam logic [VTX_W-1:0]  SCALE_RST = VTX_W'(64'd1 << FRAC_BITS);

    logic signed [TRIG_W-1:0]   r_cos, r_sin;
    logic signed [VTX_W-1:0]    r_kx, r_ky, r_px, r_py;
    logic signed [VTX_W-1:0]    r_vx, r_vy;
    logic                       r_last;
    logic signed [63:0]         r_pa;
    logic signed [SCALED_W-1:0] r_sx, r_sy;
    logic                       r_satx, r_saty;
    logic signed [RSQ_W-1:0]    r_pr;
    logic signed [63:0]         r_accx, r_accy;
    logic [RSQ_W-1:0]           r_sqx, r_len, r_max;
    logic signed [VTX_W-1:0]    r_wx, r_wy;
    logic                       r_out_valid;
    logic [VTX_W-1:0]           r_o_wx, r_o_wy;
    logic [RSQ_W-1:0]           r_o_rsq;
    logic [ROOT_W-1:0]          r_o_rad;
    logic                       r_o_rv;

    logic signed [VTX_W:0]      ma, mb;
    logic signed [2*VTX_W+1:0]  mprod;
    logic signed [63:0]         pa_shift;
    logic signed [SCALED_W-1:0] scaled;
    logic [SCALED_W-1:0]        abs_x, abs_y;
    logic signed [SCALED_W-1:0] ra;
    logic signed [TRIG_W-1:0]   rb;
    logic signed [63:0]         pr_ext;
    logic [RSQ_W-1:0]           sqy;
    logic [RSQ_W:0]             len_sum;
    logic signed [VTX_W-1:0]    wx_sat, wy_sat;
    logic                       sqrt_done;
    logic [ROOT_W-1:0]          sqrt_root;

    function automatic logic signed [VTX_W-1:0] sat32(input logic signed [63:0] v);
        if (v[63:VTX_W-1] == {(65 - VTX_W){v[63]}}) begin
            sat32 = v[VTX_W-1:0];
        end else begin
            sat32 = v[63] ? {1'b1, {(VTX_W-1){1'b0}}} : {1'b0, {(VTX_W-1){1'b1}}};
        end
    endfunction

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos <= COS_RST;
            r_sin <= '0;
            r_kx  <= SCALE_RST;
            r_ky  <= SCALE_RST;
            r_px  <= '0;
            r_py  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COS_ROT: r_cos <= i_cfg_data[TRIG_W-1:0];
                CFG_SIN_ROT: r_sin <= i_cfg_data[TRIG_W-1:0];
                CFG_SCALE_X: r_kx  <= i_cfg_data;
                CFG_SCALE_Y: r_ky  <= i_cfg_data;
                CFG_POS_X:   r_px  <= i_cfg_data;
                CFG_POS_Y:   r_py  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Shared scale and square multiplier.
    assign abs_x = r_sx[SCALED_W-1] ? SCALED_W'(-r_sx) : r_sx;
    assign abs_y = r_sy[SCALED_W-1] ? SCALED_W'(-r_sy) : r_sy;

    always_comb begin
        ma = {r_vx[VTX_W-1], r_vx};
        mb = {r_kx[VTX_W-1], r_kx};
        if (i_cmd.mul_vy) begin
            ma = {r_vy[VTX_W-1], r_vy};
            mb = {r_ky[VTX_W-1], r_ky};
        end else if (i_cmd.sq_x) begin
            ma = {1'b0, abs_x[VTX_W-1:0]};
            mb = {1'b0, abs_x[VTX_W-1:0]};
        end else if (i_cmd.sq_y) begin
            ma = {1'b0, abs_y[VTX_W-1:0]};
            mb = {1'b0, abs_y[VTX_W-1:0]};
        end
    end

    assign mprod    = ma * mb;
    assign pa_shift = r_pa >>> FRAC_BITS;

    always_comb begin
        if (pa_shift[63:SCALED_W-1] == {(65 - SCALED_W){pa_shift[63]}}) begin
            scaled = pa_shift[SCALED_W-1:0];
        end else if (pa_shift[63]) begin
            scaled = {1'b1, {(SCALED_W-1){1'b0}}};
        end else begin
            scaled = {1'b0, {(SCALED_W-1){1'b1}}};
        end
    end

    // Rotation multiplier.
    always_comb begin
        case (i_cmd.rot_sel)
            ROT_XC: begin ra = r_sx; rb = r_cos; end
            ROT_YS: begin ra = r_sy; rb = r_sin; end
            ROT_XS: begin ra = r_sx; rb = r_sin; end
            ROT_YC: begin ra = r_sy; rb = r_cos; end
            default: begin ra = r_sx; rb = r_cos; end
        endcase
    end

    assign pr_ext  = {r_pr[RSQ_W-1], r_pr};
    assign sqy     = r_saty ? RSQ_MAX : r_pa[RSQ_W-1:0];
    assign len_sum = {1'b0, r_sqx} + {1'b0, sqy};
    assign wx_sat  = sat32((r_accx >>> FRAC_BITS) + 64'(r_px));
    assign wy_sat  = sat32((r_accy >>> FRAC_BITS) + 64'(r_py));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_vx   <= i_s_axis_tdata[VTX_W-1:0];
            r_vy   <= i_s_axis_tdata[2*VTX_W-1:VTX_W];
            r_last <= i_s_axis_tlast;
        end
        if (i_cmd.mul_vx || i_cmd.mul_vy || i_cmd.sq_x || i_cmd.sq_y) begin
            r_pa <= mprod[63:0];
        end
        if (i_cmd.ld_sx) begin
            r_sx <= scaled;
        end
        if (i_cmd.ld_sy) begin
            r_sy <= scaled;
        end
        if (i_cmd.sq_x) begin
            r_satx <= abs_x > SQ_LIMIT;
        end
        if (i_cmd.sq_y) begin
            r_saty <= abs_y > SQ_LIMIT;
        end
        if (i_cmd.sqx_ld) begin
            r_sqx <= r_satx ? RSQ_MAX : r_pa[RSQ_W-1:0];
        end
        if (i_cmd.len_ld) begin
            r_len <= len_sum[RSQ_W] ? RSQ_MAX : len_sum[RSQ_W-1:0];
        end
        if (i_cmd.rot_en) begin
            r_pr <= ra * rb;
        end
        if (i_cmd.accx_ld) begin
            r_accx <= pr_ext;
        end else if (i_cmd.accx_sub) begin
            r_accx <= r_accx - pr_ext;
        end
        if (i_cmd.accy_ld) begin
            r_accy <= pr_ext;
        end else if (i_cmd.accy_add) begin
            r_accy <= r_accy + pr_ext;
        end
        if (i_cmd.wx_ld) begin
            r_wx <= wx_sat;
        end
        if (i_cmd.wy_ld) begin
            r_wy <= wy_sat;
        end
    end

    // Running maximum of the scaled squared length.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= '0;
        end else if (i_cmd.out_load && r_last) begin
            r_max <= '0;
        end else if (i_cmd.max_upd && (r_len > r_max)) begin
            r_max <= r_len;
        end
    end

    vtbr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_value (r_max),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_wx  <= r_wx;
            r_o_wy  <= r_wy;
            r_o_rsq <= r_last ? r_max : '0;
            r_o_rad <= r_last ? sqrt_root : '0;
            r_o_rv  <= r_last;
        end
    end

    assign o_status.last      = r_last;
    assign o_status.sqrt_done = sqrt_done;
    assign o_status.out_free  = !r_out_valid || i_m_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_o_rad, r_o_rsq, r_o_wy, r_o_wx};
    assign o_m_axis_tuser  = r_o_rv;

endmodule

### sv/vtbr_ctrl.sv
// ----------------------------------------------------------------------------
// vtbr_ctrl
// Controller: sequences the multiply, accumulate, square root and output
// steps of one vertex transaction.
// ----------------------------------------------------------------------------
module vtbr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  vtbr_pkg::t_status  i_status,
    output vtbr_pkg::t_cmd     o_cmd
);
    import vtbr_pkg::*;

    typedef enum logic [11:0] {
        ST_IDLE = 12'b0000_0000_0001,
        ST_MX   = 12'b0000_0000_0010,
        ST_MY   = 12'b0000_0000_0100,
        ST_R0   = 12'b0000_0000_1000,
        ST_R1   = 12'b0000_0001_0000,
        ST_R2   = 12'b0000_0010_0000,
        ST_R3   = 12'b0000_0100_0000,
        ST_R4   = 12'b0000_1000_0000,
        ST_R5   = 12'b0001_0000_0000,
        ST_SQ   = 12'b0010_0000_0000,
        ST_SQW  = 12'b0100_0000_0000,
        ST_DONE = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.rot_sel   = ROT_XC;
        o_s_axis_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_MX;
                end
            end
            ST_MX: begin
                o_cmd.mul_vx = 1'b1;
                n_state      = ST_MY;
            end
            ST_MY: begin
                o_cmd.ld_sx  = 1'b1;
                o_cmd.mul_vy = 1'b1;
                n_state      = ST_R0;
            end
            ST_R0: begin
                o_cmd.ld_sy   = 1'b1;
                o_cmd.sq_x    = 1'b1;
                o_cmd.rot_en  = 1'b1;
                o_cmd.rot_sel = ROT_XC;
                n_state       = ST_R1;
            end
            ST_R1: begin
                o_cmd.sqx_ld  = 1'b1;
                o_cmd.sq_y    = 1'b1;
                o_cmd.accx_ld = 1'b1;
                o_cmd.rot_en  = 1'b1;
                o_cmd.rot_sel = ROT_YS;
                n_state       = ST_R2;
            end
            ST_R2: begin
                o_cmd.len_ld   = 1'b1;
                o_cmd.accx_sub = 1'b1;
                o_cmd.rot_en   = 1'b1;
                o_cmd.rot_sel  = ROT_XS;
                n_state        = ST_R3;
            end
            ST_R3: begin
                o_cmd.max_upd = 1'b1;
                o_cmd.wx_ld   = 1'b1;
                o_cmd.accy_ld = 1'b1;
                o_cmd.rot_en  = 1'b1;
                o_cmd.rot_sel = ROT_YC;
                n_state       = ST_R4;
            end
            ST_R4: begin
                o_cmd.accy_add = 1'b1;
                n_state        = ST_R5;
            end
            ST_R5: begin
                o_cmd.wy_ld = 1'b1;
                n_state     = i_status.last ? ST_SQ : ST_DONE;
            end
            ST_SQ: begin
                o_cmd.sqrt_start = 1'b1;
                n_state          = ST_SQW;
            end
            ST_SQW: begin
                if (i_status.sqrt_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/vertex_transform_bounding_radius.sv
// ----------------------------------------------------------------------------
// vertex_transform_bounding_radius
// Scales, rotates and translates 2D fixed-point vertices and reports the
// bounding radius of each shape on its last vertex.
// ----------------------------------------------------------------------------
// One vertex transaction steps through the scale, rotation and accumulate
// states to the output register, and the input is ready again once the
// result is loaded, so a new vertex is accepted only after the last one is
// through. A shared 33x33 multiplier forms the two scale products and the
// two squares. A 45x18 rotation multiplier forms the four rotation products
// one per cycle and feeds the accumulators. A vertex marked by tlast adds a
// bit-serial square root of the running maximum, which resolves two radicand
// bits per cycle. The next vertex is accepted while the previous result still
// waits in the output register; the sequencer only stalls when a new result
// is ready and that register is still occupied. Configuration writes update
// the registers directly and can change a vertex already in progress.
module vertex_transform_bounding_radius #(
    parameter int FRAC_BITS = vtbr_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [vtbr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [vtbr_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // Fields from bit 0: vertex_x[31:0], vertex_y[63:32].
    input  logic [63:0]                     i_s_axis_tdata,
    input  logic                            i_s_axis_tlast,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // Fields from bit 0: world_x[31:0], world_y[63:32],
    // radius_squared[126:64], radius[158:127], zero pad[159].
    output logic [159:0]                    o_m_axis_tdata,
    // Fields from bit 0: radius_valid[0].
    output logic [0:0]                      o_m_axis_tuser
);
    import vtbr_pkg::*;

    t_cmd    cmd;
    t_status status;

    vtbr_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_status        (status),
        .o_cmd           (cmd)
    );

    vtbr_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule
